>>> hw/rtl/itc_pkg.sv
// ----------------------------------------------------------------------------
// Interval timer channel package
// Shared types, codes and defaults for the interval timer channel.
// ----------------------------------------------------------------------------
package itc_pkg;

    localparam int DEFAULT_COUNTER_WIDTH  = 16;
    localparam int DEFAULT_CHANNEL_NUMBER = 0;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_CMD  = 2'd1,
        REQ_DATA = 2'd2,
        REQ_NOP  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_PAIR  = 2'd3
    } acc_mode_t;

    localparam logic [1:0] SQUARE_MODE_BITS = 2'b11;

    typedef struct packed {
        logic [2:0] op_mode;
        acc_mode_t  acc_mode;
        logic       expect_high;
        logic       active;
        logic       level;
    } itc_ctrl_t;

    localparam itc_ctrl_t CTRL_RESET = '{
        op_mode:     3'd0,
        acc_mode:    ACC_PAIR,
        expect_high: 1'b0,
        active:      1'b0,
        level:       1'b1
    };

endpackage

>>> hw/rtl/itc_step.sv
// ----------------------------------------------------------------------------
// Interval timer channel step logic
// Combinational next-state logic for one tick, command byte or data byte.
// ----------------------------------------------------------------------------
module itc_step
    import itc_pkg::*;
#(
    parameter int COUNTER_WIDTH  = DEFAULT_COUNTER_WIDTH,
    parameter int CHANNEL_NUMBER = DEFAULT_CHANNEL_NUMBER
) (
    input  logic [1:0]               req_type,
    input  logic [7:0]               data_byte,
    input  itc_ctrl_t                ctrl_in,
    input  logic [COUNTER_WIDTH-1:0] reload_in,
    input  logic [COUNTER_WIDTH-1:0] count_in,
    output itc_ctrl_t                ctrl_out,
    output logic [COUNTER_WIDTH-1:0] reload_out,
    output logic [COUNTER_WIDTH-1:0] count_out,
    output logic                     irq_edge
);

    localparam int W = COUNTER_WIDTH;

    logic                 is_square;
    logic [W+15:0]        reload_ext;
    logic [15:0]          reload_lo16;
    logic [15:0]          new_reload16;
    logic [W+15:0]        new_reload_ext;
    logic [W-1:0]         new_reload;
    logic [1:0]           step;
    logic [W-1:0]         step_w;
    logic [W-1:0]         sub_val;
    logic [W-1:0]         dec_val;
    logic [1:0]           cmd_sel;
    logic [1:0]           chan_sel;

    assign is_square      = (ctrl_in.op_mode[1:0] == SQUARE_MODE_BITS);
    assign reload_ext     = {16'd0, reload_in};
    assign reload_lo16    = reload_ext[15:0];
    assign new_reload16   = (ctrl_in.acc_mode == ACC_LOW)  ? {8'd0, data_byte} :
                            (ctrl_in.acc_mode == ACC_HIGH) ? {data_byte, 8'd0} :
                            !ctrl_in.expect_high ? {reload_lo16[15:8], data_byte} :
                            {data_byte, reload_lo16[7:0]};
    assign new_reload_ext = {{W{1'b0}}, new_reload16};
    assign new_reload     = new_reload_ext[W-1:0];
    assign step           = count_in[0] ? (ctrl_in.level ? 2'd1 : 2'd3) : 2'd2;
    assign step_w         = {{(W-2){1'b0}}, step};
    assign sub_val        = count_in - step_w;
    assign dec_val        = count_in - {{(W-1){1'b0}}, 1'b1};
    assign cmd_sel        = data_byte[7:6];
    assign chan_sel       = CHANNEL_NUMBER[1:0];

    always_comb begin
        ctrl_out     = ctrl_in;
        reload_out   = reload_in;
        count_out    = count_in;
        case (req_type)
            REQ_TICK: begin
                if (ctrl_in.active) begin
                    if (!is_square) begin
                        count_out = dec_val;
                        if (dec_val == '0) begin
                            ctrl_out.level = 1'b1;
                        end
                    end else begin
                        if (count_in[0] && (count_in < step_w)) begin
                            count_out = '0;
                        end else begin
                            count_out = sub_val;
                        end
                        if (count_out == '0) begin
                            ctrl_out.level = !ctrl_in.level;
                            count_out      = reload_in;
                        end
                    end
                end
            end
            REQ_CMD: begin
                if ((cmd_sel == chan_sel) && (data_byte[5:4] != ACC_LATCH)) begin
                    ctrl_out.acc_mode    = acc_mode_t'(data_byte[5:4]);
                    ctrl_out.op_mode     = data_byte[3:1];
                    ctrl_out.expect_high = 1'b0;
                    ctrl_out.active      = 1'b0;
                    ctrl_out.level       = (data_byte[2:1] == SQUARE_MODE_BITS);
                end
            end
            REQ_DATA: begin
                case (ctrl_in.acc_mode)
                    ACC_LOW: begin
                        reload_out   = new_reload;
                        count_out    = new_reload;
                        ctrl_out.active = 1'b1;
                        ctrl_out.level  = is_square;
                    end
                    ACC_HIGH: begin
                        reload_out   = new_reload;
                        count_out    = new_reload;
                        ctrl_out.active = 1'b1;
                        ctrl_out.level  = is_square;
                    end
                    default: begin
                        if (!ctrl_in.expect_high) begin
                            reload_out   = new_reload;
                            ctrl_out.expect_high = 1'b1;
                            ctrl_out.active      = 1'b0;
                            if (!is_square) begin
                                ctrl_out.level = 1'b0;
                            end
                        end else begin
                            reload_out   = new_reload;
                            count_out    = new_reload;
                            ctrl_out.expect_high = 1'b0;
                            ctrl_out.active      = 1'b1;
                            ctrl_out.level       = is_square;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign irq_edge = !ctrl_in.level && ctrl_out.level;

endmodule

>>> hw/rtl/interval_timer_channel.sv
// ----------------------------------------------------------------------------
// Interval timer channel
// One channel of a programmable interval timer driven by tick, command and
// data transfers, giving one result transfer per input transfer.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload                                 Handshake
//   s_       in         req_type, data_byte                     s_valid/s_ready
//   m_       out        out_level, irq_edge, current_count      m_valid/m_ready
//
// Each transfer is taken into an input register, processed by the combinational
// step logic and written into the output register. One transfer per cycle is
// sustained while the output is not stalled, set by the single state update per cycle.
// Reset is synchronous and brings the channel to its idle, output-high state.
// A stalled output holds the result and, once the input register is full,
// lowers s_ready; no clearing pass is needed after reset.
module interval_timer_channel
    import itc_pkg::*;
#(
    parameter int COUNTER_WIDTH  = DEFAULT_COUNTER_WIDTH,
    parameter int CHANNEL_NUMBER = DEFAULT_CHANNEL_NUMBER
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_level,
    output logic        m_irq_edge,
    output logic [15:0] m_current_count
);

    localparam int W = COUNTER_WIDTH;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [1:0]           in_req_reg;
    logic [7:0]           in_byte_reg;
    logic                 advance;

    itc_ctrl_t            ctrl_reg;
    itc_ctrl_t            ctrl_next;
    logic [W-1:0]         reload_reg;
    logic [W-1:0]         reload_next;
    logic [W-1:0]         count_reg;
    logic [W-1:0]         count_next;
    logic                 irq_next;
    logic [W+15:0]        count_ext;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_level_reg;
    logic                 out_irq_reg;
    logic [15:0]          out_count_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    itc_step #(
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .CHANNEL_NUMBER (CHANNEL_NUMBER)
    ) u_step (
        .req_type   (in_req_reg),
        .data_byte  (in_byte_reg),
        .ctrl_in    (ctrl_reg),
        .reload_in  (reload_reg),
        .count_in   (count_reg),
        .ctrl_out   (ctrl_next),
        .reload_out (reload_next),
        .count_out  (count_next),
        .irq_edge   (irq_next)
    );

    assign count_ext = {16'd0, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            reload_reg    <= '0;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                ctrl_reg   <= ctrl_next;
                reload_reg <= reload_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= s_req_type;
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            out_level_reg <= ctrl_next.level;
            out_irq_reg   <= irq_next;
            out_count_reg <= count_ext[15:0];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_level     = out_level_reg;
    assign m_irq_edge      = out_irq_reg;
    assign m_current_count = out_count_reg;

`ifndef SYNTH
    a_irq_means_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_irq_edge || m_out_level))
        else $error("rising edge reported while output is low");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending input transfer lost");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_req_reg == REQ_TICK) && !ctrl_reg.active)
        |=> (count_reg == $past(count_reg)) && (ctrl_reg == $past(ctrl_reg)))
        else $error("tick changed state while counting is stopped");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed transfer produced no result");
`endif

endmodule
